### design/rrmc_pkg.sv
package rrmc_pkg;

    localparam int BUILD_W   = 6;
    localparam int DESTROY_W = 6;
    localparam int TOTAL_W   = 17;
    localparam int CFG_W     = 7;
    localparam int WEIGHT_W  = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd1;
    localparam int               REG_NODE_COUNT   = 0;

    typedef struct packed {
        logic load;
        logic start;
        logic scan_init;
        logic scan_issue;
        logic update;
        logic adj_read;
        logic adj_acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic more_nodes;
        logic scan_last;
        logic found;
        logic out_free;
    } t_sts;

endpackage

### design/rrmc_ifs.sv
interface rrmc_in_if;
    import rrmc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 road_exists;
    logic [BUILD_W-1:0]   build_cost;
    logic [DESTROY_W-1:0] destroy_cost;
    logic                 last_cell;

    modport source (output valid, output road_exists, output build_cost,
                    output destroy_cost, output last_cell, input ready);
    modport sink   (input valid, input road_exists, input build_cost,
                    input destroy_cost, input last_cell, output ready);
endinterface

interface rrmc_out_if;
    import rrmc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_cost;

    modport source (output valid, output total_cost, input ready);
    modport sink   (input valid, input total_cost, output ready);
endinterface

### design/road_rebuild_mst_cost.sv
// Road rebuild cost. Cells of the N-by-N road matrix are taken one item per
// cycle in row-major order and stored as signed weights in an on-chip edge
// memory. The item flagged last_cell starts a Prim search from node 0; no
// further items are taken until the search is done and its total has been
// handed to the output register. Each round of the search streams all N*N
// weights through the single read port of the edge memory, followed by the
// control and edge-update states, and a search ends only once the output
// register is free. The output register lets loading of the next matrix
// proceed while the last total waits to be taken. N is to be set through the
// APB register at offset 0 only while the block is idle; the block itself
// does not enforce this. 0 is taken as 1 and values above MAX_NODES are
// taken as MAX_NODES.
module road_rebuild_mst_cost #(
    parameter int MAX_NODES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rrmc_in_if.sink                         i_item,
    rrmc_out_if.source                      o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rrmc_pkg::PADDR_W-1:0]    paddr,
    input  logic [rrmc_pkg::PDATA_W-1:0]    pwdata,
    output logic [rrmc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import rrmc_pkg::*;

    logic [CFG_W-1:0] r_node_count;
    logic             reg_hit;
    t_cmd             cmd;
    t_sts             sts;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_NODE_COUNT));
    assign prdata  = reg_hit ? PDATA_W'(r_node_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_node_count <= pwdata[CFG_W-1:0];
        end
    end

    rrmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_last  (i_item.last_cell),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rrmc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_node_count   (r_node_count),
        .i_road_exists  (i_item.road_exists),
        .i_build_cost   (i_item.build_cost),
        .i_destroy_cost (i_item.destroy_cost),
        .i_last_cell    (i_item.last_cell),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_total_cost   (o_result.total_cost)
    );

endmodule

### design/rrmc_ctrl.sv
module rrmc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    output rrmc_pkg::t_cmd  o_cmd,
    input  rrmc_pkg::t_sts  i_sts
);
    import rrmc_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_DRAIN   = 3'd3;
    localparam logic [2:0] S_UPDATE  = 3'd4;
    localparam logic [2:0] S_ADJ_RD  = 3'd5;
    localparam logic [2:0] S_ADJ_ACC = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.more_nodes) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.found) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_ADJ_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_ADJ_RD: begin
                o_cmd.adj_read = 1'b1;
                n_state        = S_ADJ_ACC;
            end
            S_ADJ_ACC: begin
                o_cmd.adj_acc = 1'b1;
                n_state       = S_CHECK;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/rrmc_dp.sv
module rrmc_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rrmc_pkg::t_cmd                   i_cmd,
    output rrmc_pkg::t_sts                   o_sts,
    input  logic [rrmc_pkg::CFG_W-1:0]       i_node_count,
    input  logic                             i_road_exists,
    input  logic [rrmc_pkg::BUILD_W-1:0]     i_build_cost,
    input  logic [rrmc_pkg::DESTROY_W-1:0]   i_destroy_cost,
    input  logic                             i_last_cell,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [rrmc_pkg::TOTAL_W-1:0]     o_total_cost
);
    import rrmc_pkg::*;

    localparam int CELLS = MAX_NODES * MAX_NODES;
    localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int NW    = (CW > CFG_W) ? CW : CFG_W;

    logic [WEIGHT_W-1:0] r_mem [CELLS];

    logic [CW-1:0]        n_nodes;
    logic [CW-1:0]        n_last_idx;
    logic [NW-1:0]        cfg_ext;
    logic [WEIGHT_W-1:0]  wr_weight;
    logic [AW-1:0]        rd_addr;
    logic                 crossing;
    logic signed [WEIGHT_W-1:0] cur_w;
    logic                 take;
    logic [IW-1:0]        lo_idx;
    logic [IW-1:0]        hi_idx;
    logic                 new_i;
    logic                 new_j;

    logic [AW-1:0]        r_load;
    logic [IW-1:0]        r_si;
    logic [IW-1:0]        r_sj;
    logic [AW-1:0]        r_saddr;
    logic [MAX_NODES-1:0] r_mask;
    logic [CW-1:0]        r_added;
    logic                 r_first;
    logic [WEIGHT_W-1:0]  r_rdata;
    logic                 r_pv;
    logic                 r_pt;
    logic [IW-1:0]        r_pi;
    logic [IW-1:0]        r_pj;
    logic                 r_found;
    logic signed [WEIGHT_W-1:0] r_best;
    logic [IW-1:0]        r_bi;
    logic [IW-1:0]        r_bj;
    logic [AW-1:0]        r_adj_addr;
    logic [TOTAL_W-1:0]   r_acc;
    logic                 r_out_valid;
    logic [TOTAL_W-1:0]   r_out_total;

    // clamp N to 1..MAX_NODES
    always_comb begin
        cfg_ext = NW'(i_node_count);
        if (cfg_ext == '0) begin
            n_nodes = CW'(1);
        end else if (cfg_ext > NW'(MAX_NODES)) begin
            n_nodes = CW'(MAX_NODES);
        end else begin
            n_nodes = CW'(cfg_ext);
        end
    end

    assign n_last_idx = n_nodes - CW'(1);
    assign wr_weight  = i_road_exists ? (WEIGHT_W'(0) - WEIGHT_W'(i_destroy_cost))
                                      : WEIGHT_W'(i_build_cost);
    assign rd_addr    = i_cmd.adj_read ? r_adj_addr : r_saddr;
    assign crossing   = (r_si != r_sj) && (r_mask[r_si] != r_mask[r_sj]);
    assign cur_w      = $signed(r_rdata);
    assign take       = r_pv && (!r_found || (cur_w < r_best));
    assign lo_idx     = (r_bi < r_bj) ? r_bi : r_bj;
    assign hi_idx     = (r_bi < r_bj) ? r_bj : r_bi;
    assign new_i      = !r_mask[r_bi];
    assign new_j      = !r_mask[r_bj];

    assign o_sts.more_nodes = (r_added < n_nodes);
    assign o_sts.scan_last  = (CW'(r_si) == n_last_idx) && (CW'(r_sj) == n_last_idx);
    assign o_sts.found      = r_found;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_total_cost = r_out_total;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[r_load] <= wr_weight;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_pi <= r_si;
        r_pj <= r_sj;
        if (take) begin
            r_best <= cur_w;
            r_bi   <= r_pi;
            r_bj   <= r_pj;
        end
        if (i_cmd.update) begin
            r_adj_addr <= AW'(lo_idx) * AW'(n_nodes) + AW'(hi_idx);
        end
        if (i_cmd.out_load) begin
            r_out_total <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load      <= '0;
            r_si        <= '0;
            r_sj        <= '0;
            r_saddr     <= '0;
            r_mask      <= '0;
            r_added     <= '0;
            r_first     <= 1'b0;
            r_pv        <= 1'b0;
            r_pt        <= 1'b0;
            r_found     <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_last_cell || (r_load == AW'(CELLS - 1))) begin
                    r_load <= '0;
                end else begin
                    r_load <= r_load + AW'(1);
                end
            end

            if (i_cmd.start) begin
                r_mask    <= MAX_NODES'(1);
                r_added   <= CW'(1);
                r_first   <= 1'b1;
                r_acc     <= '0;
            end

            if (i_cmd.scan_init) begin
                r_si    <= '0;
                r_sj    <= '0;
                r_saddr <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_issue) begin
                r_saddr <= r_saddr + AW'(1);
                if (CW'(r_sj) == n_last_idx) begin
                    r_sj <= '0;
                    r_si <= r_si + IW'(1);
                end else begin
                    r_sj <= r_sj + IW'(1);
                end
            end

            r_pv <= i_cmd.scan_issue && crossing;
            r_pt <= i_cmd.scan_issue && r_first && (r_si < r_sj);

            if (take) begin
                r_found <= 1'b1;
            end

            // first round also sums every existing road of the upper triangle
            if (r_pt && cur_w[WEIGHT_W-1]) begin
                r_acc <= r_acc - TOTAL_W'(cur_w);
            end else if (i_cmd.adj_acc) begin
                r_acc <= r_acc + TOTAL_W'(cur_w);
            end

            if (i_cmd.update) begin
                r_mask  <= r_mask | (MAX_NODES'(1) << r_bi) | (MAX_NODES'(1) << r_bj);
                r_added <= r_added + CW'(new_i) + CW'(new_j);
                r_first <= 1'b0;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### design/rrmc_checker.sv
module rrmc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_last,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [rrmc_pkg::TOTAL_W-1:0] i_out_total
);

    // search start blocks further items
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("item taken right after last cell");

    // a total never becomes valid directly after the last cell is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready && i_in_last))
        else $error("result too early");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_total)))
        else $error("stalled result changed");

endmodule

bind road_rebuild_mst_cost rrmc_checker u_rrmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_last   (i_item.last_cell),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_total (o_result.total_cost)
);

### verif/road_rebuild_mst_cost_checker.sv
module road_rebuild_mst_cost_checker #(
    parameter int NODES_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rrmc_in_if                            i_cells,
    rrmc_out_if                           i_totals,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrmc_pkg::PADDR_W-1:0]  paddr,
    input  logic [rrmc_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_totals_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rrmc_pkg::*;

    localparam int PAIRS = NODES_MAX * NODES_MAX;

    logic [CFG_W-1:0]   node_cfg;
    int                 weight_mem [PAIRS];
    int                 load_addr;
    logic [TOTAL_W-1:0] totals_due [$];

    initial begin
        o_fail_count     = 0;
        o_totals_pending = 0;
    end

    function automatic int nodes_in_use();
        if (node_cfg == 0) return 1;
        if (node_cfg > NODES_MAX) return NODES_MAX;
        return int'(node_cfg);
    endfunction

    // Prim from node 0 over directed weights, first strict minimum in row-major
    // order, then cost of the upper triangle against the chosen tree.
    function automatic logic [TOTAL_W-1:0] prim_rebuild_cost(input int n);
        bit          in_tree   [NODES_MAX];
        bit          tree_edge [PAIRS];
        int          joined;
        int          best;
        int          best_i;
        int          best_j;
        int          w;
        bit          found;
        int unsigned sum;
        in_tree[0] = 1'b1;
        joined     = 1;
        sum        = 0;
        while (joined < n) begin
            found  = 1'b0;
            best   = 0;
            best_i = 0;
            best_j = 0;
            for (int i = 0; i < n; i++) begin
                for (int j = 0; j < n; j++) begin
                    if (i == j || in_tree[i] == in_tree[j]) continue;
                    w = weight_mem[i * n + j];
                    if (!found || w < best) begin
                        found  = 1'b1;
                        best   = w;
                        best_i = i;
                        best_j = j;
                    end
                end
            end
            if (!found) break;
            if (!in_tree[best_i]) joined++;
            if (!in_tree[best_j]) joined++;
            in_tree[best_i]               = 1'b1;
            in_tree[best_j]               = 1'b1;
            tree_edge[best_i * n + best_j] = 1'b1;
            tree_edge[best_j * n + best_i] = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                w = weight_mem[i * n + j];
                if (w > 0 && tree_edge[i * n + j]) sum += w;
                else if (w < 0 && !tree_edge[i * n + j]) sum += -w;
            end
        end
        return sum[TOTAL_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [TOTAL_W-1:0] want;
        if (!i_rst_n) begin
            node_cfg  = NODE_COUNT_RESET;
            load_addr = 0;
            totals_due.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == PADDR_W'(REG_NODE_COUNT * 4)) begin
                node_cfg = pwdata[CFG_W-1:0];
            end
            if (i_totals.valid && i_totals.ready) begin
                if (totals_due.size() == 0) begin
                    $error("total_cost: unexpected item, actual %0d", i_totals.total_cost);
                    o_fail_count++;
                end else begin
                    want = totals_due.pop_front();
                    if (i_totals.total_cost !== want) begin
                        $error("total_cost mismatch: expected %0d, actual %0d",
                               want, i_totals.total_cost);
                        o_fail_count++;
                    end
                end
            end
            if (i_cells.valid && i_cells.ready) begin
                weight_mem[load_addr] = i_cells.road_exists ? -int'(i_cells.destroy_cost)
                                                            : int'(i_cells.build_cost);
                load_addr = (load_addr + 1) % PAIRS;
                if (i_cells.last_cell) begin
                    totals_due = {totals_due, prim_rebuild_cost(nodes_in_use())};
                    load_addr = 0;
                end
            end
        end
        o_totals_pending <= totals_due.size();
    end

endmodule

### verif/road_rebuild_mst_cost_test.sv
module road_rebuild_mst_cost_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrmc_pkg::*;

    localparam int NODES_MAX   = 64;
    localparam int PAIRS       = NODES_MAX * NODES_MAX;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {
        FILL_RANDOM,
        FILL_TIES,
        FILL_ROADS,
        FILL_OPEN,
        FILL_ZERO,
        FILL_MAX
    } t_fill;

    typedef struct packed {
        logic                 road;
        logic [BUILD_W-1:0]   build;
        logic [DESTROY_W-1:0] destroy;
    } t_road_pair;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int totals_pending;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int cur_nodes     = 1;
    int fill_addr     = 0;
    int cells_sent    = 0;
    int matrices_sent = 0;
    bit written [PAIRS];

    rrmc_in_if  cells_if ();
    rrmc_out_if totals_if ();

    road_rebuild_mst_cost dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (cells_if),
        .o_result (totals_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    road_rebuild_mst_cost_checker #(
        .NODES_MAX (NODES_MAX)
    ) totals_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cells          (cells_if),
        .i_totals         (totals_if),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_fail_count     (fail_count),
        .o_totals_pending (totals_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin
        totals_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                totals_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                totals_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_road_pair make_pair(input t_fill style);
        t_road_pair p;
        p.road    = 1'($urandom_range(1));
        p.build   = BUILD_W'($urandom_range(63));
        p.destroy = DESTROY_W'($urandom_range(63));
        case (style)
            FILL_TIES: begin
                p.build   = BUILD_W'($urandom_range(1));
                p.destroy = DESTROY_W'($urandom_range(1));
            end
            FILL_ROADS: p.road = 1'b1;
            FILL_OPEN:  p.road = 1'b0;
            FILL_ZERO: begin
                p.build   = '0;
                p.destroy = '0;
            end
            FILL_MAX: begin
                p.build   = '1;
                p.destroy = '1;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic set_node_count(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_NODE_COUNT * 4);
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_nodes = (value == 0) ? 1 : (value > NODES_MAX) ? NODES_MAX : value;
    endtask

    task automatic drain_results();
        cells_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (totals_pending == 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_item(input t_road_pair p, input logic last);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            cells_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cells_if.valid        <= 1'b1;
        cells_if.road_exists  <= p.road;
        cells_if.build_cost   <= p.build;
        cells_if.destroy_cost <= p.destroy;
        cells_if.last_cell    <= last;
        @(posedge i_clk);
        while (!cells_if.ready) @(posedge i_clk);
        written[fill_addr] = 1'b1;
        fill_addr = last ? 0 : (fill_addr + 1) % PAIRS;
        cells_sent++;
        if (last) matrices_sent++;
    endtask

    task automatic send_matrix(input int count, input t_fill style);
        for (int k = 0; k < count; k++) begin
            send_item(make_pair(style), k == count - 1);
        end
    endtask

    // mostly exact loads; some overlong, some short where the tail is already stored
    task automatic send_random_matrix();
        int count;
        int roll;
        int cut;
        bit whole;
        count = cur_nodes * cur_nodes;
        roll  = $urandom_range(99);
        if (roll < 10) begin
            count += $urandom_range(1, 5);
        end else if (roll < 16 && count > 1) begin
            cut   = $urandom_range(1, count - 1);
            whole = 1'b1;
            for (int a = cut; a < count; a++) whole &= written[a];
            if (whole) count = cut;
        end
        send_matrix(count, t_fill'($urandom_range(FILL_MAX)));
    endtask

    initial begin
        int roll;
        int budget;
        bit paused;
        paused = 1'b0;
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        cells_if.valid        <= 1'b0;
        cells_if.road_exists  <= 1'b0;
        cells_if.build_cost   <= '0;
        cells_if.destroy_cost <= '0;
        cells_if.last_cell    <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single node after reset, two-node corner fills and an overlong load, then node count 0
        send_matrix(1, FILL_MAX);
        settle();
        set_node_count(2);
        send_matrix(4, FILL_MAX);
        send_matrix(4, FILL_ZERO);
        send_matrix(4, FILL_ROADS);
        send_matrix(4, FILL_TIES);
        send_matrix(6, FILL_RANDOM);
        settle();
        set_node_count(0);
        send_matrix(1, FILL_OPEN);

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 68 : 0;
            rx_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 27 : 0;
            for (int s = 0; s < 4; s++) begin
                settle();
                roll = $urandom_range(99);
                set_node_count(roll < 8  ? $urandom_range(1) :
                               roll < 80 ? $urandom_range(2, 6) : $urandom_range(7, 12));
                budget = cells_sent + 60;
                while (cells_sent < budget) begin
                    send_random_matrix();
                    if (mode == 0 && s == 1 && !paused) begin
                        drain_results();
                        paused = 1'b1;
                    end
                end
            end
        end

        // back pressure: results held off while small matrices keep coming
        settle();
        set_node_count(2);
        hold_asked++;
        repeat (30) send_matrix(4, FILL_RANDOM);

        drain_results();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d items in %0d matrices: node counts 0 to 12, ties,",
                 cells_sent, matrices_sent);
        $display("overlong and short loads, stalls and a long result hold-off");
        if (fail_count == 0 && totals_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
